// ===== hdl/etq_pkg.sv =====
// shared types and constants for the euler to quaternion converter
// cordic arctangent table, payload structs and internal widths
`timescale 1ns / 1ps

package etq_pkg;

	localparam int ANGLE_W      = 16;
	localparam int QUAT_W       = 16;
	localparam int CORDIC_STEPS = 30;
	localparam int CORDIC_W     = 33;
	localparam int TRIG_W       = 22;
	localparam int PAIR_W       = 2 * TRIG_W;
	localparam int TRIPLE_W     = 3 * TRIG_W;
	localparam int SUM_W        = TRIPLE_W + 1;
	localparam int ROUND_SHIFT  = 46;

	localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 16'sd25736;
	localparam logic signed [QUAT_W-1:0]  UNIT_Q14    = 16'sd16384;
	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] roll_angle;
		logic signed [ANGLE_W-1:0] pitch_angle;
		logic signed [ANGLE_W-1:0] yaw_angle;
	} angle_t;

	typedef struct packed {
		logic signed [QUAT_W-1:0] quat_w;
		logic signed [QUAT_W-1:0] quat_x;
		logic signed [QUAT_W-1:0] quat_y;
		logic signed [QUAT_W-1:0] quat_z;
	} quat_t;

	function automatic logic signed [CORDIC_W-1:0] atan_q30(input int idx);
		logic signed [CORDIC_W-1:0] r;
		case (idx)
			0: r = 33'sd843314857;
			1: r = 33'sd497837829;
			2: r = 33'sd263043837;
			3: r = 33'sd133525159;
			4: r = 33'sd67021687;
			5: r = 33'sd33543516;
			6: r = 33'sd16775851;
			7: r = 33'sd8388437;
			8: r = 33'sd4194283;
			9: r = 33'sd2097149;
			default: r = (idx < 30) ? (33'sd1 <<< (30 - idx)) : 33'sd0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/etq_cordic.sv =====
// one angle lane: saturation, half angle, 30 pipelined cordic steps, rounding
// gives cosine and sine of the half angle in units of 2^-20; uses etq_pkg
`timescale 1ns / 1ps

module etq_cordic (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [etq_pkg::ANGLE_W-1:0]    angle,
	output logic signed [etq_pkg::TRIG_W-1:0]     cos_val,
	output logic signed [etq_pkg::TRIG_W-1:0]     sin_val
);

	localparam int N = etq_pkg::CORDIC_STEPS;
	localparam int W = etq_pkg::CORDIC_W;

	logic signed [W-1:0] x_s [0:N];
	logic signed [W-1:0] y_s [0:N];
	logic signed [W-1:0] z_s [0:N];
	logic signed [etq_pkg::ANGLE_W-1:0] sat_angle;
	logic signed [W-1:0] x_rnd;
	logic signed [W-1:0] y_rnd;

	always_comb begin
		if (angle > etq_pkg::ANGLE_LIMIT)
			sat_angle = etq_pkg::ANGLE_LIMIT;
		else if (angle < -etq_pkg::ANGLE_LIMIT)
			sat_angle = -etq_pkg::ANGLE_LIMIT;
		else
			sat_angle = angle;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= etq_pkg::CORDIC_GAIN_Q30;
			y_s[0] <= '0;
			z_s[0] <= W'(sat_angle) <<< 16;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		logic signed [W-1:0] dx;
		logic signed [W-1:0] dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][W-1]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - etq_pkg::atan_q30(i);
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + etq_pkg::atan_q30(i);
				end
			end
		end
	end

	assign x_rnd = (x_s[N] + W'(512)) >>> 10;
	assign y_rnd = (y_s[N] + W'(512)) >>> 10;

	always_ff @(posedge clk) begin
		if (en) begin
			cos_val <= x_rnd[etq_pkg::TRIG_W-1:0];
			sin_val <= y_rnd[etq_pkg::TRIG_W-1:0];
		end
	end

endmodule

// ===== hdl/etq_combine.sv =====
// quaternion assembly: pair products, triple products, sum, round and clamp
// three register stages; uses etq_pkg
`timescale 1ns / 1ps

module etq_combine (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [etq_pkg::TRIG_W-1:0]   cr,
	input  logic signed [etq_pkg::TRIG_W-1:0]   sr,
	input  logic signed [etq_pkg::TRIG_W-1:0]   cp,
	input  logic signed [etq_pkg::TRIG_W-1:0]   sp,
	input  logic signed [etq_pkg::TRIG_W-1:0]   cy,
	input  logic signed [etq_pkg::TRIG_W-1:0]   sy,
	output etq_pkg::quat_t                      quat
);

	localparam int PW = etq_pkg::PAIR_W;
	localparam int TW = etq_pkg::TRIPLE_W;
	localparam int SW = etq_pkg::SUM_W;

	logic signed [PW-1:0] cc_s1, ss_s1, sc_s1, cs_s1;
	logic signed [etq_pkg::TRIG_W-1:0] cy_s1, sy_s1;
	logic signed [TW-1:0] w0_s2, w1_s2, x0_s2, x1_s2, y0_s2, y1_s2, z0_s2, z1_s2;

	function automatic logic signed [etq_pkg::QUAT_W-1:0] finish(
		input logic signed [SW-1:0] sum
	);
		logic signed [SW-1:0] v;
		v = (sum + (SW'(1) <<< (etq_pkg::ROUND_SHIFT - 1))) >>> etq_pkg::ROUND_SHIFT;
		if (v > SW'(etq_pkg::UNIT_Q14))
			return etq_pkg::UNIT_Q14;
		else if (v < -SW'(etq_pkg::UNIT_Q14))
			return -etq_pkg::UNIT_Q14;
		else
			return v[etq_pkg::QUAT_W-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			cc_s1 <= PW'(cr) * PW'(cp);
			ss_s1 <= PW'(sr) * PW'(sp);
			sc_s1 <= PW'(sr) * PW'(cp);
			cs_s1 <= PW'(cr) * PW'(sp);
			cy_s1 <= cy;
			sy_s1 <= sy;
			w0_s2 <= TW'(cc_s1) * TW'(cy_s1);
			w1_s2 <= TW'(ss_s1) * TW'(sy_s1);
			x0_s2 <= TW'(sc_s1) * TW'(cy_s1);
			x1_s2 <= TW'(cs_s1) * TW'(sy_s1);
			y0_s2 <= TW'(cs_s1) * TW'(cy_s1);
			y1_s2 <= TW'(sc_s1) * TW'(sy_s1);
			z0_s2 <= TW'(cc_s1) * TW'(sy_s1);
			z1_s2 <= TW'(ss_s1) * TW'(cy_s1);
			quat.quat_w <= finish(SW'(w0_s2) + SW'(w1_s2));
			quat.quat_x <= finish(SW'(x0_s2) - SW'(x1_s2));
			quat.quat_y <= finish(SW'(y0_s2) + SW'(y1_s2));
			quat.quat_z <= finish(SW'(z0_s2) - SW'(z1_s2));
		end
	end

endmodule

// ===== hdl/euler_to_quaternion.sv =====
// euler angles (zyx) to rotation quaternion, fully pipelined
// one transaction per cycle; the whole pipe holds while the output is stalled
// reset clears only the valid bits; data registers are not reset
// depends on etq_pkg, etq_cordic, etq_combine
`timescale 1ns / 1ps

module euler_to_quaternion (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              angle_valid,
	output logic              angle_stall,
	input  etq_pkg::angle_t   angle,
	output logic              quat_valid,
	input  logic              quat_stall,
	output etq_pkg::quat_t    quat
);

	localparam int LAT = etq_pkg::CORDIC_STEPS + 5;

	logic [LAT-1:0] valid_q;
	logic en;
	logic signed [etq_pkg::TRIG_W-1:0] cr, sr, cp, sp, cy, sy;

	assign en          = !(valid_q[LAT-1] && quat_stall);
	assign angle_stall = !en;
	assign quat_valid  = valid_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[LAT-2:0], angle_valid};
		end
	end

	etq_cordic u_roll (
		.clk(clk), .en(en), .angle(angle.roll_angle), .cos_val(cr), .sin_val(sr)
	);

	etq_cordic u_pitch (
		.clk(clk), .en(en), .angle(angle.pitch_angle), .cos_val(cp), .sin_val(sp)
	);

	etq_cordic u_yaw (
		.clk(clk), .en(en), .angle(angle.yaw_angle), .cos_val(cy), .sin_val(sy)
	);

	etq_combine u_combine (
		.clk(clk), .en(en),
		.cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
		.quat(quat)
	);

endmodule
